@@ rtl/pidm_pkg.sv @@
`default_nettype none

package pidm_pkg;

  // field widths
  localparam int DATA_W     = 16;
  localparam int ERR_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 11;
  localparam int U_W        = 18;
  localparam int INT_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // loop constants, 4 ms sample period
  localparam int D_SCALE      = 250;
  localparam int I_DIVISOR    = 500;
  localparam int I_RND        = 250;
  localparam int I_SHIFT      = 8;
  localparam int ITERM_SHIFT  = 8;
  localparam int U_LIMIT      = 102400;
  localparam int INTEG_LIMIT  = 26214400;
  localparam int DIV_R_W      = $clog2(I_DIVISOR);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_BASE_DUTY,
    REG_DUTY_LIMIT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_ROUND,
    S_DIV,
    S_INTEG,
    S_SUM,
    S_CLAMP,
    S_MIX
  } state_t;

  // control of a bit-serial unit
  typedef struct packed {
    logic load;
    logic step;
  } serial_ctl_t;

endpackage

`default_nettype wire

@@ rtl/pidm_mul.sv @@
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle while step is high
module pidm_mul #(
  parameter int A_W = 16
) (
  input  logic                              clk,
  input  pidm_pkg::serial_ctl_t             ctl,
  input  logic [A_W-1:0]                    a,
  input  logic [pidm_pkg::GAIN_W-1:0]       b,
  output logic [A_W+pidm_pkg::GAIN_W-1:0]   prod
);
  import pidm_pkg::*;

  logic [A_W-1:0]        areg;
  logic [A_W+GAIN_W-1:0] p;
  logic [A_W:0]          part;

  always_comb begin
    part = {1'b0, p[A_W+GAIN_W-1:GAIN_W]} + (p[0] ? {1'b0, areg} : {(A_W+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      areg <= a;
      p    <= {{A_W{1'b0}}, b};
    end else if (ctl.step) begin
      p <= {part, p[GAIN_W-1:1]};
    end
  end

  assign prod = p;

endmodule

`default_nettype wire

@@ rtl/pidm_div.sv @@
`default_nettype none

// restoring divide by the integral divisor, one quotient bit per cycle while step is high
module pidm_div #(
  parameter int Y_W = 34
) (
  input  logic                  clk,
  input  pidm_pkg::serial_ctl_t ctl,
  input  logic [Y_W-1:0]        dividend,
  output logic [Y_W-1:0]        quotient
);
  import pidm_pkg::*;

  logic [Y_W-1:0]     q;
  logic [DIV_R_W-1:0] r;
  logic [DIV_R_W:0]   trial;
  logic [DIV_R_W:0]   rem_sub;
  logic               fits;

  always_comb begin
    trial   = {r, q[Y_W-1]};
    fits    = trial >= (DIV_R_W+1)'(I_DIVISOR);
    rem_sub = trial - (DIV_R_W+1)'(I_DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= dividend;
      r <= '0;
    end else if (ctl.step) begin
      q <= {q[Y_W-2:0], fits};
      r <= fits ? rem_sub[DIV_R_W-1:0] : trial[DIV_R_W-1:0];
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire

@@ rtl/pid_roll_balance_mixer.sv @@
// Rate PID with two-motor mixing. Each sample transfer on measured_rate (Q8.8) yields one
// result transfer: control_value u = clamp(P + I + D, +-400.0) in Q8.8, left_duty =
// base_duty - u and right_duty = base_duty + u, both truncated toward zero, floored at 0
// and saturated from above at duty_limit. The integral is kept in Q10.16 and clamped to
// +-400.0; it and the previous error reset to zero. Gains carry GAIN_FRAC_BITS fraction
// bits. Each sample runs through setup, the three bit-serial gain multipliers side by
// side, rounding, the bit-serial divide that scales the integral step, integral update,
// summing, clamping and mixing. A finished result sits in an output register, so a new
// sample can be taken while the result is still stalled. Configuration writes are always
// ready and must only be issued while the block is idle.
`default_nettype none

module pid_roll_balance_mixer #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [pidm_pkg::DATA_W-1:0]  measured_rate,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [pidm_pkg::U_W-1:0]     control_value,
  output logic [pidm_pkg::DUTY_W-1:0]         left_duty,
  output logic [pidm_pkg::DUTY_W-1:0]         right_duty
);
  import pidm_pkg::*;

  localparam int G = GAIN_FRAC_BITS;

  // operand magnitudes: |error|, |error sum|, |error diff| * 250
  localparam int EM_W = DATA_W;
  localparam int SM_W = DATA_W + 1;
  localparam int DA_W = SM_W + 8;
  // product widths
  localparam int PP_W = GAIN_W + EM_W;
  localparam int IP_W = GAIN_W + SM_W;
  localparam int DP_W = GAIN_W + DA_W;
  // rounded terms
  localparam int P_MAG_W = PP_W + 1 - G;
  localparam int P_W     = P_MAG_W + 1;
  localparam int D_MAG_W = DP_W + 1 - G;
  localparam int D_W     = D_MAG_W + 1;
  localparam int PD_W    = D_W + 1;
  localparam int S_W     = PD_W + 1;
  // integral step dividend and update
  localparam int Y_W   = IP_W + I_SHIFT + 1 - G;
  localparam int IV_W  = Y_W + 2;
  localparam int CNT_W = $clog2(Y_W);
  localparam int IT_MAG_W = INT_W + 1 - ITERM_SHIFT;

  localparam logic [PP_W:0]   P_HALF  = (PP_W+1)'(1) << (G - 1);
  localparam logic [DP_W:0]   D_HALF  = (DP_W+1)'(1) << (G - 1);
  localparam logic [INT_W:0]  IT_HALF = (INT_W+1)'(1) << (ITERM_SHIFT - 1);

  localparam logic signed [IV_W-1:0]  IV_MAX  = IV_W'(INTEG_LIMIT);
  localparam logic signed [IV_W-1:0]  IV_MIN  = -IV_MAX;
  localparam logic signed [INT_W-1:0] INT_MAX = INT_W'(INTEG_LIMIT);
  localparam logic signed [INT_W-1:0] INT_MIN = -INT_MAX;
  localparam logic signed [S_W-1:0]   S_MAX   = S_W'(U_LIMIT);
  localparam logic signed [S_W-1:0]   S_MIN   = -S_MAX;
  localparam logic signed [U_W-1:0]   U_MAX   = U_W'(U_LIMIT);
  localparam logic signed [U_W-1:0]   U_MIN   = -U_MAX;

  // reset values of the registers
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = GAIN_W'(14080);
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = GAIN_W'(128);
  localparam logic [DUTY_W-1:0] RST_BASE_DUTY  = DUTY_W'(1050);
  localparam logic [DUTY_W-1:0] RST_DUTY_LIMIT = DUTY_W'(1200);

  // truncate toward zero, floor at 0, saturate from above at the limit
  function automatic logic [DUTY_W-1:0] duty_sat(input logic signed [DUTY_W+9:0] v,
                                                 input logic [DUTY_W-1:0] limit);
    logic [DUTY_W:0]   whole;
    logic [DUTY_W-1:0] res;
    whole = v[DUTY_W+8:8];
    if (v[DUTY_W+9]) begin
      res = '0;
    end else if (whole > {1'b0, limit}) begin
      res = limit;
    end else begin
      res = whole[DUTY_W-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0] setpoint;
  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [GAIN_W-1:0]        deriv_gain;
  logic [DUTY_W-1:0]        base_duty;
  logic [DUTY_W-1:0]        duty_limit;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  serial_ctl_t        mul_ctl;
  serial_ctl_t        div_ctl;
  logic               out_load;

  // loop state
  logic signed [ERR_W-1:0] last_error;
  logic signed [INT_W-1:0] integral;

  // datapath
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W:0]   e_sum;
  logic signed [ERR_W:0]   e_diff;
  logic [ERR_W-1:0]        err_abs;
  logic [ERR_W:0]          sum_abs;
  logic [ERR_W:0]          diff_abs;
  logic [EM_W-1:0]         mag_p;
  logic [SM_W-1:0]         mag_i;
  logic [DA_W-1:0]         mag_d;
  logic                    neg_p;
  logic                    neg_i;
  logic                    neg_d;
  logic [PP_W-1:0]         prod_p;
  logic [IP_W-1:0]         prod_i;
  logic [DP_W-1:0]         prod_d;
  logic [PP_W:0]           p_rnd;
  logic [DP_W:0]           d_rnd;
  logic [P_MAG_W:0]        p_ext;
  logic [D_MAG_W:0]        d_ext;
  logic signed [P_W-1:0]   p_term;
  logic signed [D_W-1:0]   d_term;
  logic signed [PD_W-1:0]  pd;
  logic [IP_W+I_SHIFT-1:0] i_wide;
  logic [Y_W-1:0]          i_dividend;
  logic [Y_W-1:0]          i_quot;
  logic signed [Y_W:0]     inc;
  logic signed [IV_W-1:0]  iv;
  logic [INT_W-1:0]        int_abs;
  logic [INT_W:0]          it_rnd;
  logic [IT_MAG_W:0]       it_ext;
  logic signed [IT_MAG_W:0] it_term;
  logic signed [S_W-1:0]   s;
  logic signed [U_W-1:0]   u;
  logic signed [DUTY_W+9:0] base_ext;
  logic signed [DUTY_W+9:0] v_left;
  logic signed [DUTY_W+9:0] v_right;

  // --------------------------------------------------------------------------
  // configuration port, never stalls
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= '0;
      prop_gain  <= RST_PROP_GAIN;
      integ_gain <= RST_INTEG_GAIN;
      deriv_gain <= RST_DERIV_GAIN;
      base_duty  <= RST_BASE_DUTY;
      duty_limit <= RST_DUTY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:   setpoint   <= cfg_data;
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_BASE_DUTY:  base_duty  <= cfg_data[DUTY_W-1:0];
        REG_DUTY_LIMIT: duty_limit <= cfg_data[DUTY_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (sample_valid) state_next = S_PREP;
      S_PREP:  state_next = S_MUL;
      S_MUL:   if (cnt == CNT_W'(GAIN_W - 1)) state_next = S_ROUND;
      S_ROUND: state_next = S_DIV;
      S_DIV:   if (cnt == CNT_W'(Y_W - 1)) state_next = S_INTEG;
      S_INTEG: state_next = S_SUM;
      S_SUM:   state_next = S_CLAMP;
      S_CLAMP: state_next = S_MIX;
      // wait here only while the previous result is still held off
      S_MIX:   if (!result_valid || !result_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    mul_ctl      = '0;
    div_ctl      = '0;
    out_load     = 1'b0;
    case (state)
      S_IDLE:  sample_stall = 1'b0;
      S_PREP:  mul_ctl.load = 1'b1;
      S_MUL:   mul_ctl.step = 1'b1;
      S_ROUND: div_ctl.load = 1'b1;
      S_DIV:   div_ctl.step = 1'b1;
      S_MIX:   out_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  // bit counter for the serial units
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == S_MUL || state == S_DIV) begin
      cnt <= cnt + CNT_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // error terms: sign and magnitude go to the multipliers separately
  // --------------------------------------------------------------------------
  always_comb begin
    e_sum    = (ERR_W+1)'(err) + (ERR_W+1)'(last_error);
    e_diff   = (ERR_W+1)'(err) - (ERR_W+1)'(last_error);
    err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    sum_abs  = e_sum[ERR_W] ? (ERR_W+1)'(-e_sum) : (ERR_W+1)'(e_sum);
    diff_abs = e_diff[ERR_W] ? (ERR_W+1)'(-e_diff) : (ERR_W+1)'(e_diff);
    mag_p    = err_abs[EM_W-1:0];
    mag_i    = sum_abs[SM_W-1:0];
    // derivative divides by the 4 ms period, i.e. scales by 250
    mag_d    = DA_W'(diff_abs[SM_W-1:0]) * DA_W'(D_SCALE);
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && sample_valid) begin
      err <= ERR_W'(setpoint) - ERR_W'(measured_rate);
    end
    if (state == S_PREP) begin
      neg_p <= err[ERR_W-1];
      neg_i <= e_sum[ERR_W];
      neg_d <= e_diff[ERR_W];
    end
  end

  // three gain products, run side by side
  pidm_mul #(.A_W(EM_W)) u_mul_p (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (mag_p),
    .b    (prop_gain),
    .prod (prod_p)
  );

  pidm_mul #(.A_W(SM_W)) u_mul_i (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (mag_i),
    .b    (integ_gain),
    .prod (prod_i)
  );

  pidm_mul #(.A_W(DA_W)) u_mul_d (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (mag_d),
    .b    (deriv_gain),
    .prod (prod_d)
  );

  // --------------------------------------------------------------------------
  // rounding: add half, drop the gain fraction, ties go away from zero
  // --------------------------------------------------------------------------
  always_comb begin
    p_rnd = {1'b0, prod_p} + P_HALF;
    d_rnd = {1'b0, prod_d} + D_HALF;
    p_ext = {1'b0, P_MAG_W'(p_rnd >> G)};
    d_ext = {1'b0, D_MAG_W'(d_rnd >> G)};
    // integral step: ki*sum*256 / (500 * 2^G), the half-divisor folded in after the shift
    i_wide     = {prod_i, {I_SHIFT{1'b0}}};
    i_dividend = Y_W'(i_wide >> G) + Y_W'(I_RND);
  end

  pidm_div #(.Y_W(Y_W)) u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (i_dividend),
    .quotient (i_quot)
  );

  always_comb begin
    inc     = neg_i ? -$signed({1'b0, i_quot}) : $signed({1'b0, i_quot});
    iv      = IV_W'(integral) + IV_W'(inc);
    // integral back to Q8.8 with rounding
    int_abs = integral[INT_W-1] ? INT_W'(-integral) : INT_W'(integral);
    it_rnd  = {1'b0, int_abs} + IT_HALF;
    it_ext  = {1'b0, IT_MAG_W'(it_rnd >> ITERM_SHIFT)};
    it_term = integral[INT_W-1] ? -$signed(it_ext) : $signed(it_ext);
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      p_term <= neg_p ? -$signed(p_ext) : $signed(p_ext);
      d_term <= neg_d ? -$signed(d_ext) : $signed(d_ext);
    end
    if (state == S_DIV) begin
      pd <= PD_W'(p_term) + PD_W'(d_term);
    end
    if (state == S_SUM) begin
      s <= S_W'(pd) + S_W'(it_term);
    end
    if (state == S_CLAMP) begin
      if (s > S_MAX) begin
        u <= U_MAX;
      end else if (s < S_MIN) begin
        u <= U_MIN;
      end else begin
        u <= U_W'(s);
      end
    end
  end

  // loop state: previous error and clamped integral
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integral   <= '0;
    end else begin
      if (state == S_PREP) begin
        last_error <= err;
      end
      if (state == S_INTEG) begin
        if (iv > IV_MAX) begin
          integral <= INT_MAX;
        end else if (iv < IV_MIN) begin
          integral <= INT_MIN;
        end else begin
          integral <= INT_W'(iv);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // motor mix and output register
  // --------------------------------------------------------------------------
  always_comb begin
    base_ext = $signed({2'b00, base_duty, 8'h00});
    v_left   = base_ext - (DUTY_W+10)'(u);
    v_right  = base_ext + (DUTY_W+10)'(u);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      control_value <= u;
      left_duty     <= duty_sat(v_left, duty_limit);
      right_duty    <= duty_sat(v_right, duty_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // the stored integral never leaves its clamp range
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    integral <= INT_MAX && integral >= INT_MIN)
    else $error("integral out of range");

  // a presented result is always within the control clamp
  a_u_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (control_value <= U_MAX && control_value >= U_MIN))
    else $error("control value out of range");

  // once a sample is taken, the next one is held off
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("second sample taken while busy");

  // multiplier steps stop after the gain width
  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> cnt < CNT_W'(GAIN_W))
    else $error("multiplier step count overrun");
`endif

endmodule

`default_nettype wire

@@ verif/pid_mixer_check.sv @@
`timescale 1ns / 100ps

module pid_mixer_check #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [pidm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                sample_valid,
  input  logic                                sample_stall,
  input  logic signed [pidm_pkg::DATA_W-1:0]  measured_rate,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic signed [pidm_pkg::U_W-1:0]     control_value,
  input  logic [pidm_pkg::DUTY_W-1:0]         left_duty,
  input  logic [pidm_pkg::DUTY_W-1:0]         right_duty,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam longint GAIN_DEN = longint'(1) << GAIN_FRAC_BITS;
  localparam longint Q88_ONE  = 256;
  localparam longint U_MAX    = 102400;
  localparam longint ITG_MAX  = 26214400;
  localparam longint D_RATE   = 250;
  localparam longint I_DIV    = 500;

  typedef struct packed {
    logic signed [17:0] u;
    logic [10:0]        left;
    logic [10:0]        right;
  } mix_out_t;

  logic signed [15:0] sp_r;
  logic [15:0]        kp_r, ki_r, kd_r;
  logic [10:0]        base_r, limit_r;
  logic signed [16:0] err_prev;
  logic signed [31:0] integ_acc;
  mix_out_t           mix_expected[$];
  mix_out_t           want;

  // round to nearest, ties away from zero
  function automatic longint div_nearest(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint sat(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // truncate toward zero, floor at 0, cap at the limit
  function automatic logic [10:0] duty_of(input longint q88);
    longint whole;
    whole = ((q88 < 0) ? -q88 : q88) / Q88_ONE;
    if (q88 < 0) whole = -whole;
    if (whole < 0) whole = 0;
    if (whole > longint'(limit_r)) whole = longint'(limit_r);
    return whole[10:0];
  endfunction

  // one controller step, advances error and integral
  function automatic mix_out_t next_mix(input logic signed [15:0] rate);
    longint e, p, inc, d, itg, u, base;
    mix_out_t r;
    e = longint'(sp_r) - longint'(rate);
    p = div_nearest(longint'(kp_r) * e, GAIN_DEN);
    inc = div_nearest(longint'(ki_r) * (e + longint'(err_prev)) * Q88_ONE, I_DIV * GAIN_DEN);
    itg = sat(longint'(integ_acc) + inc, ITG_MAX);
    d = div_nearest(longint'(kd_r) * (e - longint'(err_prev)) * D_RATE, GAIN_DEN);
    u = sat(p + div_nearest(itg, Q88_ONE) + d, U_MAX);
    err_prev = e[16:0];
    integ_acc = itg[31:0];
    base = longint'(base_r) * Q88_ONE;
    r.u = u[17:0];
    r.left = duty_of(base - u);
    r.right = duty_of(base + u);
    return r;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sp_r = '0;
      kp_r = 16'd14080;
      ki_r = 16'd256;
      kd_r = 16'd128;
      base_r = 11'd1050;
      limit_r = 11'd1200;
      err_prev = '0;
      integ_acc = '0;
      mix_expected.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (pidm_pkg::cfg_reg_t'(cfg_index))
          pidm_pkg::REG_SETPOINT:   sp_r = cfg_data;
          pidm_pkg::REG_PROP_GAIN:  kp_r = cfg_data;
          pidm_pkg::REG_INTEG_GAIN: ki_r = cfg_data;
          pidm_pkg::REG_DERIV_GAIN: kd_r = cfg_data;
          pidm_pkg::REG_BASE_DUTY:  base_r = cfg_data[10:0];
          pidm_pkg::REG_DUTY_LIMIT: limit_r = cfg_data[10:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (mix_expected.size() == 0) begin
          mismatches++;
          $error("result transfer with nothing expected: control_value %0d", control_value);
        end else begin
          want = mix_expected.pop_front();
          check_field("control_value", longint'($signed(want.u)), longint'(control_value));
          check_field("left_duty", longint'(want.left), longint'(left_duty));
          check_field("right_duty", longint'(want.right), longint'(right_duty));
        end
      end
      if (sample_valid && !sample_stall) mix_expected.push_back(next_mix(measured_rate));
      outstanding <= mix_expected.size();
    end
  end

endmodule

@@ verif/pid_roll_balance_mixer_tb.sv @@
`timescale 1ns / 100ps

module pid_roll_balance_mixer_tb;

  import pidm_pkg::*;

  localparam int GAIN_FRAC     = 8;
  localparam int CLK_PERIOD    = 10;
  // watchdog limit, leaves plenty of room over the slowest run
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 1000;
  localparam int DRAIN_CYCLES  = 70;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 130;
  localparam int FINAL_ITEMS   = 60;
  localparam int PRESSURE_ITEMS = 40;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = CFG_IDX_W'(REG_DUTY_LIMIT + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [DATA_W-1:0] measured_rate = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic signed [U_W-1:0]   control_value;
  logic [DUTY_W-1:0]       left_duty;
  logic [DUTY_W-1:0]       right_duty;

  int mismatches;
  int outstanding;
  int cycle_count = 0;

  // idle controls, percent chance of a gap per item / stall per cycle
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;

  // current setpoint, used to center samples around it
  logic signed [15:0] aim_rate = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  pid_roll_balance_mixer #(.GAIN_FRAC_BITS(GAIN_FRAC)) uut (.*);

  pid_mixer_check #(.GAIN_FRAC_BITS(GAIN_FRAC)) checker_i (.*);

  // one register write, cfg_valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SETPOINT) aim_rate = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one sample transfer, with an optional gap before it
  task automatic send_rate(input logic [15:0] v);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    measured_rate <= v;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // drop valid and wait until every expected result has been seen
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1024));
      3: return 16'($urandom_range(20000));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly in the stated duty range, sometimes raw 16 bits to hit masking
  function automatic logic [15:0] pick_duty();
    case ($urandom_range(5))
      0: return 16'd1000;
      1: return 16'd2000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(2000, 1000));
    endcase
  endfunction

  // mostly near the setpoint so the loop leaves saturation, rest full range
  function automatic logic [15:0] pick_rate();
    int spread;
    if ($urandom_range(9) < 3) return 16'($urandom);
    case ($urandom_range(2))
      0: spread = 16;
      1: spread = 256;
      default: spread = 4096;
    endcase
    return 16'(int'(aim_rate) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic random_config();
    if ($urandom_range(3) == 0)
      write_reg(REG_SETPOINT, $urandom_range(1) ? 16'h7FFF : 16'h8000);
    else
      write_reg(REG_SETPOINT, 16'($urandom));
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_BASE_DUTY, pick_duty());
    write_reg(REG_DUTY_LIMIT, pick_duty());
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? IDX_UNUSED_LO : IDX_UNUSED_HI, 16'($urandom));
    close_cfg();
  endtask

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        holds_done++;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(15, 1)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL pid_roll_balance_mixer");
    $finish;
  end

  initial begin
    logic [15:0] corner_rates[9];
    logic [15:0] swing_rates[4];
    logic [15:0] floor_rates[3];
    logic [15:0] clip_rates[5];
    corner_rates = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                     16'h5555, 16'hAAAA, 16'h0100, 16'hFF00};
    swing_rates = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000};
    floor_rates = '{16'h8000, 16'h7FFF, 16'h0000};
    clip_rates = '{16'h0080, 16'hFF80, 16'h0200, 16'hFE00, 16'h0000};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: sample extremes and alternating bit patterns
    gap_pct = 20;
    stall_pct = 5;
    foreach (corner_rates[i]) send_rate(corner_rates[i]);
    settle();

    // largest gains and the most negative setpoint, drives both clamps
    write_reg(REG_SETPOINT, 16'h8000);
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    write_reg(REG_DERIV_GAIN, 16'hFFFF);
    write_reg(REG_BASE_DUTY, 16'd2000);
    write_reg(REG_DUTY_LIMIT, 16'd2000);
    close_cfg();
    foreach (swing_rates[i]) send_rate(swing_rates[i]);
    settle();

    // zero gains hold the integral, base of zero pushes one duty below zero
    write_reg(REG_SETPOINT, 16'h7FFF);
    write_reg(REG_PROP_GAIN, 16'h0000);
    write_reg(REG_INTEG_GAIN, 16'h0000);
    write_reg(REG_DERIV_GAIN, 16'h0000);
    write_reg(REG_BASE_DUTY, 16'h0000);
    write_reg(REG_DUTY_LIMIT, 16'h07FF);
    close_cfg();
    foreach (floor_rates[i]) send_rate(floor_rates[i]);
    settle();

    // upper bits of the duty registers get masked, limit cuts one side only,
    // writes past the register list change nothing
    write_reg(REG_SETPOINT, 16'h0000);
    write_reg(REG_PROP_GAIN, 16'd14080);
    write_reg(REG_INTEG_GAIN, 16'd256);
    write_reg(REG_DERIV_GAIN, 16'd128);
    write_reg(REG_BASE_DUTY, 16'hFBE8);
    write_reg(REG_DUTY_LIMIT, 16'hFCB0);
    write_reg(IDX_UNUSED_LO, 16'hFFFF);
    write_reg(IDX_UNUSED_HI, 16'h0000);
    close_cfg();
    foreach (clip_rates[i]) send_rate(clip_rates[i]);
    settle();

    // long hold-off on the result side while samples keep coming
    gap_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    repeat (PRESSURE_ITEMS) send_rate(pick_rate());
    settle();

    // random settings, each phase with its own idle mix
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config();
      gap_pct = (ph % 3) * 20;
      stall_pct = ((ph + 1) % 3) * 4;
      repeat (PHASE_ITEMS) send_rate(pick_rate());
      settle();
    end

    // closing stretch at full rate
    random_config();
    gap_pct = 0;
    stall_pct = 0;
    repeat (FINAL_ITEMS) send_rate(pick_rate());
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS pid_roll_balance_mixer");
    else
      $display("FAIL pid_roll_balance_mixer");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pidm_pkg.sv
rtl/pidm_mul.sv
rtl/pidm_div.sv
rtl/pid_roll_balance_mixer.sv
verif/pid_mixer_check.sv
verif/pid_roll_balance_mixer_tb.sv
